@@ rtl/lrupr_pkg.sv @@
// Shared constants, types and structs for the LRU page replacement block.
package lrupr_pkg;

    localparam int FRAMES     = 8;
    localparam int PAGE_BITS  = 16;
    localparam int FRAME_BITS = $clog2(FRAMES);
    localparam int OCC_BITS   = $clog2(FRAMES + 1);
    localparam int CFG_BITS   = 4;
    localparam int INDEX_BITS = 3;
    localparam int COUNT_BITS = 16;
    localparam int LIMIT_BITS = ((OCC_BITS > CFG_BITS) ? OCC_BITS : CFG_BITS) + 1;

    localparam logic [CFG_BITS-1:0] CFG_RESET = CFG_BITS'(8);

    typedef logic [FRAME_BITS-1:0] frame_idx_t;
    typedef logic [FRAME_BITS-1:0] rank_t;
    typedef logic [PAGE_BITS-1:0]  page_t;
    typedef logic [COUNT_BITS-1:0] count_t;

    // Outcome of one reference against the current frame state
    typedef struct packed {
        logic       hit;
        frame_idx_t slot;
        logic       evicted;
        page_t      evicted_page;
        count_t     fault_total;
    } lookup_t;

    // Occupancy view of the frame set
    typedef struct packed {
        logic [FRAMES-1:0]   valid;
        logic [OCC_BITS-1:0] occupied;
    } frame_status_t;

endpackage

@@ rtl/lrupr_frames.sv @@
// Frame table with page tags, recency ranks, fault counter and the one-pass update.
module lrupr_frames
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              fire,
    input  lrupr_pkg::page_t                  page,
    input  logic [lrupr_pkg::CFG_BITS-1:0]    frames_in_use,
    output lrupr_pkg::lookup_t                result,
    output lrupr_pkg::frame_status_t          status
);
    import lrupr_pkg::*;

    page_t               frame_pages_reg [FRAMES];
    logic [FRAMES-1:0]   frame_valid_reg;
    logic [FRAMES-1:0]   frame_valid_next;
    rank_t               rank_reg [FRAMES];
    rank_t               rank_next [FRAMES];
    count_t              fault_reg;
    count_t              fault_next;

    logic [LIMIT_BITS-1:0] cfg_ext;
    logic [LIMIT_BITS-1:0] limit;
    logic [OCC_BITS-1:0]   occupied;
    logic [OCC_BITS-1:0]   occ_m1;
    logic [FRAMES-1:0]     match;
    logic [FRAMES-1:0]     victim_sel;
    logic                  hit;
    logic                  fill;
    frame_idx_t            hit_slot;
    frame_idx_t            free_slot;
    frame_idx_t            victim_slot;
    frame_idx_t            slot;
    rank_t                 ref_rank;

    always_comb
    begin
        cfg_ext = LIMIT_BITS'(frames_in_use);
        if (cfg_ext == '0)
        begin
            limit = LIMIT_BITS'(1);
        end
        else if (cfg_ext > LIMIT_BITS'(FRAMES))
        begin
            limit = LIMIT_BITS'(FRAMES);
        end
        else
        begin
            limit = cfg_ext;
        end

        occupied = '0;
        for (int f = 0; f < FRAMES; f++)
        begin
            occupied = occupied + OCC_BITS'(frame_valid_reg[f]);
        end
        occ_m1 = occupied - OCC_BITS'(1);

        // Valid frames hold distinct ranks 0..occupied-1, so the oldest has rank occupied-1
        for (int f = 0; f < FRAMES; f++)
        begin
            match[f]      = frame_valid_reg[f] && (frame_pages_reg[f] == page);
            victim_sel[f] = frame_valid_reg[f] && (rank_reg[f] == rank_t'(occ_m1));
        end

        // Lowest index wins in each priority search
        hit_slot    = '0;
        free_slot   = '0;
        victim_slot = '0;
        for (int f = FRAMES - 1; f >= 0; f--)
        begin
            if (match[f])
            begin
                hit_slot = frame_idx_t'(f);
            end
            if (!frame_valid_reg[f])
            begin
                free_slot = frame_idx_t'(f);
            end
            if (victim_sel[f])
            begin
                victim_slot = frame_idx_t'(f);
            end
        end

        hit  = |match;
        fill = !hit && (LIMIT_BITS'(occupied) < limit);

        if (hit)
        begin
            slot = hit_slot;
        end
        else if (fill)
        begin
            slot = free_slot;
        end
        else
        begin
            slot = victim_slot;
        end
        ref_rank = rank_reg[slot];

        frame_valid_next = frame_valid_reg;
        for (int f = 0; f < FRAMES; f++)
        begin
            if (frame_idx_t'(f) == slot)
            begin
                rank_next[f] = '0;
            end
            else if (frame_valid_reg[f] && (fill || (rank_reg[f] < ref_rank)))
            begin
                rank_next[f] = rank_reg[f] + rank_t'(1);
            end
            else
            begin
                rank_next[f] = rank_reg[f];
            end
        end
        if (fill)
        begin
            frame_valid_next[slot] = 1'b1;
        end

        fault_next = fault_reg;
        if (!hit && (fault_reg != '1))
        begin
            fault_next = fault_reg + count_t'(1);
        end

        result.hit          = hit;
        result.slot         = slot;
        result.evicted      = !hit && !fill;
        result.evicted_page = (!hit && !fill) ? frame_pages_reg[slot] : '0;
        result.fault_total  = fault_next;

        status.valid    = frame_valid_reg;
        status.occupied = occupied;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_valid_reg <= '0;
            fault_reg       <= '0;
            for (int f = 0; f < FRAMES; f++)
            begin
                rank_reg[f] <= '0;
            end
        end
        else if (fire)
        begin
            frame_valid_reg <= frame_valid_next;
            fault_reg       <= fault_next;
            for (int f = 0; f < FRAMES; f++)
            begin
                rank_reg[f] <= rank_next[f];
            end
        end
    end

    // Tags need no reset: an entry is only compared or read while its valid bit is set
    always_ff @(posedge clk)
    begin
        if (fire && !hit)
        begin
            frame_pages_reg[slot] <= page;
        end
    end

endmodule

@@ rtl/lru_page_replacement.sv @@
// Top level of the LRU page replacement block: handshakes, config register, result register.
//
//  channel   direction  handshake              payload
//  --------  ---------  ---------------------  --------------------------------------------
//  in        input      in_valid / in_stall    page_number
//  out       output     out_valid / out_stall  hit, frame_index, evicted_valid,
//                                              evicted_page, fault_total
//  cfg       input      cfg_wr_en              cfg_wr_data (frames_in_use)
//
//  One reference per cycle while out_stall is low; the page register captures each reference
//  on its input transfer and the result register then loads its lookup outcome, which is
//  offered on the output. The single lookup and rank update pass sits between the
//  page register and the result register; the frame table updates on the same edge,
//  so the next reference already sees it.
//  Reset (rst_n low, asynchronous) empties all frames, clears ranks and the fault
//  count and sets frames_in_use to 8.
//  out_stall holds the result register and, once the page register is also full,
//  raises in_stall in the same cycle.
module lru_page_replacement
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              cfg_wr_en,
    input  logic [lrupr_pkg::CFG_BITS-1:0]    cfg_wr_data,

    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [lrupr_pkg::PAGE_BITS-1:0]   page_number,

    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              hit,
    output logic [lrupr_pkg::INDEX_BITS-1:0]  frame_index,
    output logic                              evicted_valid,
    output logic [lrupr_pkg::PAGE_BITS-1:0]   evicted_page,
    output logic [lrupr_pkg::COUNT_BITS-1:0]  fault_total
);
    import lrupr_pkg::*;

    logic [CFG_BITS-1:0] frames_in_use_reg;

    // Page register stage
    logic  in_vld_reg;
    logic  in_vld_next;
    page_t page_reg;

    // Result register stage
    logic   out_vld_reg;
    logic   out_vld_next;
    logic   hit_reg;
    logic [INDEX_BITS-1:0] index_reg;
    logic   evict_reg;
    page_t  evict_page_reg;
    count_t fault_total_reg;

    logic          out_free;
    logic          fire;
    logic          in_xfer;
    lookup_t       lookup;
    frame_status_t status;

    // Result slot is free when empty or being drained this cycle
    assign out_free = !out_vld_reg || !out_stall;
    assign fire     = in_vld_reg && out_free;
    assign in_stall = in_vld_reg && !out_free;
    assign in_xfer  = in_valid && !in_stall;

    assign in_vld_next  = in_xfer || (in_vld_reg && !fire);
    assign out_vld_next = fire || (out_vld_reg && out_stall);

    lrupr_frames u_frames
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .page          (page_reg),
        .frames_in_use (frames_in_use_reg),
        .result        (lookup),
        .status        (status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_in_use_reg <= CFG_RESET;
            in_vld_reg        <= 1'b0;
            out_vld_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                frames_in_use_reg <= cfg_wr_data;
            end
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Payload registers: capture on transfer, hold otherwise
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            page_reg <= page_number;
        end
        if (fire)
        begin
            hit_reg         <= lookup.hit;
            index_reg       <= INDEX_BITS'(lookup.slot);
            evict_reg       <= lookup.evicted;
            evict_page_reg  <= lookup.evicted_page;
            fault_total_reg <= lookup.fault_total;
        end
    end

    assign out_valid     = out_vld_reg;
    assign hit           = hit_reg;
    assign frame_index   = index_reg;
    assign evicted_valid = evict_reg;
    assign evicted_page  = evict_page_reg;
    assign fault_total   = fault_total_reg;

    // Frame occupancy changes only on a lookup pass
    a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(status.valid))
        else $error("frame valid bits changed without a lookup");

    // A hit never changes occupancy
    a_hit_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && lookup.hit) |=> $stable(status.valid))
        else $error("frame valid bits changed on a hit");

    // A fill occupies exactly one more frame
    a_fill_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !lookup.hit && !lookup.evicted) |=>
        ($countones(status.valid) == $past($countones(status.valid)) + 1))
        else $error("fill did not occupy exactly one frame");

    // An eviction is only reported for a fault
    a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && evict_reg) |-> !hit_reg)
        else $error("eviction reported together with a hit");

endmodule
